// File: rtl/core/mavg_pkg.sv
// Package for the moving average filter: shared constants and types.
// Used by the filter top level and its port checker; depends on nothing.

package mavg_pkg;

  // default geometry
  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  // register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int WLEN_W     = 9;

  typedef logic [WLEN_W-1:0] wlen_t;

  localparam wlen_t WLEN_RESET = wlen_t'(250);

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW_LEN = 1'b0;

endpackage

// File: rtl/core/moving_average_filter_unit.sv
// Each sample passes through the update state and, once the window is full, the
// shift-subtract divider, one quotient bit per cycle; while the window fills the
// divider is skipped. One item is in flight at a time: a new sample is taken only
// after the last result has been loaded into the output register.
// Reset (rst, synchronous): window_len = 250, window empty, output stage empty.
// The sample ring has no reset; entries are always written before their value is used.

module moving_average_filter_unit #(
  parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream; s_tdata: sample
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
  // result stream; m_tdata: average; m_tuser: window_full
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,
  output logic                              m_tuser,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mavg_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mavg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mavg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import mavg_pkg::*;

  localparam int DATA_W = ((SAMPLE_BITS+7)/8)*8;
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + SLOT_W;
  localparam int CNT_W  = $clog2(SUM_W);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]              state;
  wlen_t                   window_len;
  logic [SLOT_W-1:0]       write_slot;
  logic [SLOT_W-1:0]       cur_slot;
  logic [LEN_W-1:0]        fill_count;
  logic signed [SUM_W-1:0] running_sum;
  logic [SAMPLE_BITS-1:0]  samp;
  logic [SAMPLE_BITS-1:0]  rd_data;
  logic [SAMPLE_BITS-1:0]  ring [MAX_WINDOW];
  logic                    res_full;
  logic                    res_neg;
  logic [SUM_W-1:0]        div_q;
  logic [LEN_W-1:0]        div_rem;
  logic [CNT_W-1:0]        div_cnt;
  logic [SAMPLE_BITS-1:0]  out_avg;
  logic                    out_full;

  logic                    cfg_wr;
  logic                    s_acc;
  logic [LEN_W-1:0]        eff_len;
  logic [SLOT_W-1:0]       slot_eff;
  logic [LEN_W-1:0]        slot_inc;
  logic [SLOT_W-1:0]       write_slot_next;
  logic                    full_before;
  logic [LEN_W-1:0]        fill_count_next;
  logic signed [SUM_W-1:0] running_sum_next;
  logic [SUM_W-1:0]        sum_mag;
  logic [LEN_W:0]          rem_sh;
  logic                    rem_ge;
  logic [SUM_W-1:0]        quot;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LEN);
  assign prdata   = (paddr[2] == REG_WINDOW_LEN) ? APB_DATA_W'(window_len) : '0;
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign m_tdata  = DATA_W'(out_avg);
  assign m_tuser  = out_full;

  // effective window length, clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(window_len);
    end
  end

  // slot to read and overwrite for the next sample
  assign slot_eff = (LEN_W'(write_slot) >= eff_len) ? '0 : write_slot;
  assign slot_inc = LEN_W'(cur_slot) + LEN_W'(1);
  assign write_slot_next = (slot_inc >= eff_len) ? '0 : SLOT_W'(slot_inc);

  // running sum: add new sample, drop the leaving one once full
  assign full_before     = (fill_count >= eff_len);
  assign fill_count_next = full_before ? fill_count : fill_count + LEN_W'(1);
  always_comb begin
    if (full_before) begin
      running_sum_next = running_sum + SUM_W'($signed(samp)) - SUM_W'($signed(rd_data));
    end else begin
      running_sum_next = running_sum + SUM_W'($signed(samp));
    end
  end
  assign sum_mag = running_sum_next[SUM_W-1] ? SUM_W'(-running_sum_next)
                                             : SUM_W'(running_sum_next);

  // one restoring divide step
  assign rem_sh = {div_rem, div_q[SUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, eff_len});
  assign quot   = res_neg ? SUM_W'(-div_q) : div_q;

  // sample ring: registered read at acceptance, write-back in update
  always_ff @(posedge clk) begin
    if (s_acc) begin
      rd_data <= ring[slot_eff];
    end
    if (state == ST_UPDATE) begin
      ring[cur_slot] <= samp;
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      window_len  <= WLEN_RESET;
      write_slot  <= '0;
      fill_count  <= '0;
      running_sum <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // output register: load from the done state, clear once taken
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr) begin
        window_len  <= pwdata[WLEN_W-1:0];
        write_slot  <= '0;
        fill_count  <= '0;
        running_sum <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            samp     <= s_tdata[SAMPLE_BITS-1:0];
            cur_slot <= slot_eff;
            state    <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          running_sum <= running_sum_next;
          fill_count  <= fill_count_next;
          write_slot  <= write_slot_next;
          res_full    <= (fill_count_next >= eff_len);
          res_neg     <= running_sum_next[SUM_W-1];
          div_q       <= sum_mag;
          div_rem     <= '0;
          div_cnt     <= '0;
          state       <= (fill_count_next >= eff_len) ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          div_rem <= rem_ge ? LEN_W'(rem_sh - {1'b0, eff_len}) : LEN_W'(rem_sh);
          div_q   <= {div_q[SUM_W-2:0], rem_ge};
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(SUM_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // load the output register once it is free
          if (!m_tvalid || m_tready) begin
            out_avg  <= res_full ? quot[SAMPLE_BITS-1:0] : samp;
            out_full <= res_full;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/mavg_checker.sv
// Port-level checker for the moving average filter, bound to the top level.
// Depends on mavg_pkg and on the port names of moving_average_filter_unit.

module mavg_checker #(
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
  input logic                             m_tuser,
  input logic                             pready
);
  import mavg_pkg::*;

  // reset leaves the output empty and the input side open
  a_reset_state: assert property (@(posedge clk) rst |=> (!m_tvalid && s_tready))
    else $error("state after reset wrong");

  // one item at a time: input closes after each transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // configuration port never inserts wait states
  a_no_wait: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind moving_average_filter_unit mavg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mavg_chk (.*);

// File: tb/sv/tb_moving_average_filter_unit.sv
// Self-checking testbench for the moving average (boxcar) filter unit.
// Drives samples and window-length writes, predicts each mean in-bench and
// checks every result transaction; depends on mavg_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_moving_average_filter_unit;
  import mavg_pkg::*;

  localparam int SB         = SAMPLE_BITS_DEF;
  localparam int WIN_MAX    = MAX_WINDOW_DEF;
  localparam int DATA_W     = ((SB + 7) / 8) * 8;
  localparam int CYCLE_CAP  = 500000;
  localparam int DRAIN_WAIT = 30;
  localparam int HOLD_AT    = 500;
  localparam int HOLD_LEN   = 200;
  localparam int PRINT_CAP  = 40;

  // byte addresses of register index 0 and of an unused index
  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_LEN = {REG_WINDOW_LEN, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED     = {~REG_WINDOW_LEN, 2'b00};

  // short windows, extremes and truncation toward zero
  localparam logic [SB-1:0] SINGLE_TAP [0:6] = '{
    16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
  localparam logic [SB-1:0] PAIR_TAP [0:9] = '{
    16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF,
    16'h0000, 16'hFFFD, 16'h0000, 16'h0001, 16'h8000};

  typedef struct packed {
    logic [SB-1:0] average;
    logic          window_full;
  } mean_t;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata  = '0;   // sample
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_W-1:0]     m_tdata;         // average
  logic                  m_tuser;         // window_full
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // stimulus and expectation stores
  logic [SB-1:0] sample_backlog [$];
  mean_t         awaited_means [$];

  // predictor state
  wlen_t                cfg_wlen = WLEN_RESET;
  logic signed [SB-1:0] ring_hist [WIN_MAX];
  int                   ring_slot = 0;
  int                   held      = 0;
  longint               run_sum   = 0;

  int mismatch_count = 0;
  int results_seen   = 0;
  int cycle_count    = 0;
  int idle_pct       = 0;
  int in_gap         = 0;
  int out_gap        = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  moving_average_filter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // one boxcar step: running sum update, ring write, mean or pass-through
  task automatic advance_boxcar(input logic [SB-1:0] raw);
    int     len;
    longint smp;
    mean_t  m;
    len = (cfg_wlen == 0) ? 1 : ((cfg_wlen > WIN_MAX) ? WIN_MAX : int'(cfg_wlen));
    smp = longint'($signed(raw));
    if (ring_slot >= len) ring_slot = 0;
    if (held < len) begin
      run_sum += smp;
      held++;
    end else begin
      run_sum += smp - longint'(ring_hist[ring_slot]);
    end
    ring_hist[ring_slot] = $signed(raw);
    ring_slot++;
    if (ring_slot >= len) ring_slot = 0;
    m.window_full = (held >= len);
    m.average     = m.window_full ? SB'(run_sum / longint'(len)) : raw;
    awaited_means.push_back(m);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                          output logic [APB_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // register write plus the matching predictor update; any index-0 write restarts fill
  task automatic write_window_reg(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
    apb_write(addr, data);
    if (addr[2] == REG_WINDOW_LEN) begin
      cfg_wlen  = data[WLEN_W-1:0];
      ring_slot = 0;
      held      = 0;
      run_sum   = 0;
    end
  endtask

  task automatic confirm_window_len();
    logic [APB_DATA_W-1:0] rd;
    apb_read(ADDR_WINDOW_LEN, rd);
    if (rd[WLEN_W-1:0] !== cfg_wlen)
      report_mismatch("window_len readback", rd, 32'(cfg_wlen));
  endtask

  // full-scale corners, small values for truncation, and mostly plain random
  function automatic logic [SB-1:0] pick_sample();
    logic signed [SB-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'sh7FFF;
      1: v = 16'sh8000;
      2: v = $signed(SB'($urandom_range(0, 8))) - 16'sd4;
      default: v = SB'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_random(input int n);
    repeat (n) sample_backlog.push_back(pick_sample());
  endtask

  // sender stays quiet until every awaited mean is back and the pipe is empty
  task automatic wait_drained();
    while (sample_backlog.size() != 0 || s_tvalid || awaited_means.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // sample driver: predicts on each accepted transaction, then offers the next
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (s_tvalid && s_tready) advance_boxcar(s_tdata[SB-1:0]);
      if (!s_tvalid || s_tready) begin
        if (in_gap > 0) begin
          s_tvalid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (sample_backlog.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= DATA_W'(sample_backlog.pop_front());
          if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            in_gap <= $urandom_range(1, 5);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stalls, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      out_gap   <= 0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      m_tready  <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
    end else if (out_gap > 0) begin
      m_tready <= 1'b0;
      out_gap  <= out_gap - 1;
    end else begin
      m_tready <= 1'b1;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        out_gap <= $urandom_range(1, 5);
    end
  end

  // result monitor
  always @(posedge clk) begin
    mean_t m;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (awaited_means.size() == 0) begin
        report_mismatch("unexpected result", 32'(m_tdata), 0);
      end else begin
        m = awaited_means.pop_front();
        if (m_tdata[SB-1:0] !== m.average)
          report_mismatch("average", 32'(m_tdata), 32'(m.average));
        if (m_tuser !== m.window_full)
          report_mismatch("window_full", 32'(m_tuser), 32'(m.window_full));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_moving_average_filter_unit NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 20;

    // reset window length; an unused index must not restart the fill
    confirm_window_len();
    queue_random(120);
    wait_drained();
    write_window_reg(ADDR_UNUSED, 32'd5);
    confirm_window_len();
    queue_random(160);
    wait_drained();

    // length zero acts as one: every sample is its own mean
    write_window_reg(ADDR_WINDOW_LEN, 32'd0);
    confirm_window_len();
    foreach (SINGLE_TAP[i]) sample_backlog.push_back(SINGLE_TAP[i]);
    wait_drained();

    // two taps: sums at the rails and negative odd sums
    write_window_reg(ADDR_WINDOW_LEN, 32'd2);
    confirm_window_len();
    foreach (PAIR_TAP[i]) sample_backlog.push_back(PAIR_TAP[i]);
    wait_drained();

    // largest field value saturates to the ring depth; pause mid-stream
    write_window_reg(ADDR_WINDOW_LEN, 32'd511);
    confirm_window_len();
    queue_random(150);
    wait_drained();
    queue_random(150);
    wait_drained();

    // upper write-data bits are dropped, leaving exactly the ring depth
    write_window_reg(ADDR_WINDOW_LEN, 32'hABCD_E100);
    confirm_window_len();
    queue_random(270);
    wait_drained();

    // short windows with varying idle density
    for (int k = 0; k < 6; k++) begin
      idle_pct = $urandom_range(0, 30);
      write_window_reg(ADDR_WINDOW_LEN, (k == 0) ? 32'd1 : 32'($urandom_range(2, 40)));
      confirm_window_len();
      queue_random(50);
      wait_drained();
    end

    // closing stretch at full rate
    idle_pct = 0;
    write_window_reg(ADDR_WINDOW_LEN, 32'd3);
    confirm_window_len();
    queue_random(85);
    wait_drained();

    if (mismatch_count == 0)
      $display("tb_moving_average_filter_unit OK");
    else
      $display("tb_moving_average_filter_unit NOT OK");
    $finish;
  end

endmodule
